[rtl/core/efsd_pkg.sv]
// ----------------------------------------------------------------------------
// efsd_pkg: shared types and constants for the earliest-free server dispatcher
// Field widths, the server count and the request/result types of the shared
// add/subtract unit.
// ----------------------------------------------------------------------------
package efsd_pkg;

  localparam int MAX_SERVERS = 8;                    // servers held in state
  localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W       = $clog2(MAX_SERVERS + 1);

  localparam int TIME_W = 32;                        // arrival, free time, wait, idle
  localparam int SVC_W  = 16;                        // service time
  localparam int JOB_W  = 32;                        // job counts
  localparam int SUM_W  = 48;                        // saturating sums
  localparam int SRV_W  = 3;                         // server index on the port
  localparam int CFG_W  = 4;                         // servers_in_use register

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef enum logic [1:0] {
    ALU_SUB,      // a - b, flag = borrow (a < b)
    ALU_ADD32,    // a + b, saturate at 2^32-1
    ALU_ADD48     // a + b, saturate at 2^48-1
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [SUM_W-1:0]  a;
    logic [SUM_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0]  res;
    logic              borrow;
  } alu_rsp_t;

endpackage

[rtl/core/efsd_alu.sv]
// ----------------------------------------------------------------------------
// efsd_alu: shared add/subtract unit
// One 49-bit adder; subtract by inverted operand and carry-in, saturating
// add at 32 or 48 bits.
// ----------------------------------------------------------------------------
module efsd_alu (
  input  efsd_pkg::alu_req_t req,
  output efsd_pkg::alu_rsp_t rsp
);
  import efsd_pkg::*;

  localparam logic [SUM_W-1:0] CAP48 = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0] CAP32 = SUM_W'({TIME_W{1'b1}});

  logic [SUM_W-1:0] b_eff;
  logic             cin;
  logic [SUM_W:0]   sum;

  assign b_eff = (req.op == ALU_SUB) ? ~req.b : req.b;
  assign cin   = (req.op == ALU_SUB);
  assign sum   = {1'b0, req.a} + {1'b0, b_eff} + {{SUM_W{1'b0}}, cin};

  always_comb begin
    rsp.borrow = 1'b0;
    unique case (req.op)
      ALU_SUB: begin
        rsp.res    = sum[SUM_W-1:0];
        rsp.borrow = ~sum[SUM_W];
      end
      ALU_ADD32: begin
        // operands fit in 33 bits, so any upper bit set means overflow
        rsp.res = (sum[SUM_W:TIME_W] != '0) ? CAP32 : sum[SUM_W-1:0];
      end
      ALU_ADD48: begin
        rsp.res = sum[SUM_W] ? CAP48 : sum[SUM_W-1:0];
      end
      default: begin
        rsp.res = sum[SUM_W-1:0];
      end
    endcase
  end

endmodule

[rtl/core/earliest_free_server_dispatch.sv]
// Per request: a scan of the n active servers (n = 1..8), the wait, idle and update
//   steps, then emit; no new request is taken until the result is emitted. The scan
//   and the nine wait, idle and update steps all share one 49-bit add/subtract unit.
// A finished result sits in the output register while the next request is taken.
// Reset (rst_n low, synchronous): all free times, counts and sums clear to zero,
//   servers_in_use returns to 8, no result is pending.
// ----------------------------------------------------------------------------
// earliest_free_server_dispatch: earliest-free server job dispatcher
// Picks the server with the earliest free time among the active ones (lowest
// index on a tie), computes wait or idle time and keeps saturating totals.
// ----------------------------------------------------------------------------
module earliest_free_server_dispatch (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [efsd_pkg::CFG_W-1:0]   cfg_wr_data,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [efsd_pkg::TIME_W-1:0]  in_arrival_time,
  input  logic [efsd_pkg::SVC_W-1:0]   in_service_time,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [efsd_pkg::SRV_W-1:0]   out_server,
  output logic [efsd_pkg::TIME_W-1:0]  out_wait_time,
  output logic [efsd_pkg::TIME_W-1:0]  out_idle_time,
  output logic [efsd_pkg::JOB_W-1:0]   out_server_jobs,
  output logic [efsd_pkg::SUM_W-1:0]   out_server_wait_sum,
  output logic [efsd_pkg::SUM_W-1:0]   out_server_idle_sum,
  output logic [efsd_pkg::JOB_W-1:0]   out_all_jobs,
  output logic [efsd_pkg::SUM_W-1:0]   out_all_wait_sum,
  output logic [efsd_pkg::SUM_W-1:0]   out_all_idle_sum
);
  import efsd_pkg::*;

  // Sequencer: one step per cycle unless idle or emit holds; others use the unit once.
  typedef enum logic [3:0] {
    S_IDLE,    // wait for a request
    S_SCAN,    // compare free_at[idx] against best so far
    S_WCHK,    // best - arrival -> wait time
    S_ICHK,    // arrival - best -> idle time, busy flag
    S_FREE,    // new free time, saturating at 32 bits
    S_WSUM,    // per-server wait sum
    S_ISUM,    // per-server idle sum
    S_JOBS,    // per-server job count
    S_TWAIT,   // total wait
    S_TIDLE,   // total idle
    S_TJOBS,   // total jobs
    S_EMIT     // commit state, load output register
  } state_t;

  localparam logic [7:0] MAX8 = 8'(MAX_SERVERS);

  // server state
  logic [TIME_W-1:0] free_at_r  [MAX_SERVERS];
  logic [SUM_W-1:0]  wait_sum_r [MAX_SERVERS];
  logic [SUM_W-1:0]  idle_sum_r [MAX_SERVERS];
  logic [JOB_W-1:0]  job_cnt_r  [MAX_SERVERS];
  logic [JOB_W-1:0]  tot_jobs_r;
  logic [SUM_W-1:0]  tot_wait_r;
  logic [SUM_W-1:0]  tot_idle_r;
  logic [CFG_W-1:0]  srv_cfg_r;

  // per-request working registers
  state_t            state_r;
  logic [TIME_W-1:0] arr_r;
  logic [SVC_W-1:0]  svc_r;
  logic [TIME_W-1:0] best_r;
  logic [IDX_W-1:0]  pick_r;
  logic [CNT_W-1:0]  idx_r;
  logic [TIME_W-1:0] wait_r;
  logic [TIME_W-1:0] idle_r;
  logic              busy_r;
  logic [TIME_W-1:0] new_free_r;
  logic [SUM_W-1:0]  wsum_r;
  logic [SUM_W-1:0]  isum_r;
  logic [JOB_W-1:0]  jobs_r;
  logic [SUM_W-1:0]  twait_r;
  logic [SUM_W-1:0]  tidle_r;
  logic [JOB_W-1:0]  tjobs_r;

  // output register
  logic              out_valid_r;
  logic [SRV_W-1:0]  o_server_r;
  logic [TIME_W-1:0] o_wait_r;
  logic [TIME_W-1:0] o_idle_r;
  logic [JOB_W-1:0]  o_sjobs_r;
  logic [SUM_W-1:0]  o_swait_r;
  logic [SUM_W-1:0]  o_sidle_r;
  logic [JOB_W-1:0]  o_ajobs_r;
  logic [SUM_W-1:0]  o_await_r;
  logic [SUM_W-1:0]  o_aidle_r;

  logic [CNT_W-1:0]  act_cnt;
  logic [TIME_W-1:0] scan_val;
  logic              in_fire;
  logic              emit;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  // Active server count: 0 acts as 1, anything above the array acts as full.
  always_comb begin
    if (srv_cfg_r == '0) begin
      act_cnt = CNT_W'(1);
    end else if ({4'b0, srv_cfg_r} > MAX8) begin
      act_cnt = CNT_W'(MAX_SERVERS);
    end else begin
      act_cnt = CNT_W'(srv_cfg_r);
    end
  end

  assign scan_val = free_at_r[idx_r[IDX_W-1:0]];
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  // result moves out only when the output register is empty or draining
  assign emit     = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // Operand select for the shared unit.
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state_r)
      S_SCAN: begin
        alu_req.a = SUM_W'(scan_val);
        alu_req.b = SUM_W'(best_r);
      end
      S_WCHK: begin
        alu_req.a = SUM_W'(best_r);
        alu_req.b = SUM_W'(arr_r);
      end
      S_ICHK: begin
        alu_req.a = SUM_W'(arr_r);
        alu_req.b = SUM_W'(best_r);
      end
      S_FREE: begin
        alu_req.op = ALU_ADD32;
        alu_req.a  = SUM_W'(busy_r ? best_r : arr_r);
        alu_req.b  = SUM_W'(svc_r);
      end
      S_WSUM: begin
        alu_req.op = ALU_ADD48;
        alu_req.a  = wait_sum_r[pick_r];
        alu_req.b  = SUM_W'(wait_r);
      end
      S_ISUM: begin
        alu_req.op = ALU_ADD48;
        alu_req.a  = idle_sum_r[pick_r];
        alu_req.b  = SUM_W'(idle_r);
      end
      S_JOBS: begin
        alu_req.op = ALU_ADD32;
        alu_req.a  = SUM_W'(job_cnt_r[pick_r]);
        alu_req.b  = SUM_W'(1);
      end
      S_TWAIT: begin
        alu_req.op = ALU_ADD48;
        alu_req.a  = tot_wait_r;
        alu_req.b  = SUM_W'(wait_r);
      end
      S_TIDLE: begin
        alu_req.op = ALU_ADD48;
        alu_req.a  = tot_idle_r;
        alu_req.b  = SUM_W'(idle_r);
      end
      S_TJOBS: begin
        alu_req.op = ALU_ADD32;
        alu_req.a  = SUM_W'(tot_jobs_r);
        alu_req.b  = SUM_W'(1);
      end
      S_IDLE, S_EMIT: begin
        alu_req.op = ALU_SUB;
      end
      default: begin
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  efsd_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      srv_cfg_r   <= CFG_RESET;
      tot_jobs_r  <= '0;
      tot_wait_r  <= '0;
      tot_idle_r  <= '0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
        free_at_r[i]  <= '0;
        wait_sum_r[i] <= '0;
        idle_sum_r[i] <= '0;
        job_cnt_r[i]  <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        srv_cfg_r <= cfg_wr_data;
      end

      // a new result loading in the same cycle keeps valid high
      if (out_valid_r && out_ready && !emit) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            arr_r  <= in_arrival_time;
            svc_r  <= in_service_time;
            best_r <= free_at_r[0];
            pick_r <= '0;
            idx_r  <= CNT_W'(1);
            state_r <= (act_cnt == CNT_W'(1)) ? S_WCHK : S_SCAN;
          end
        end
        S_SCAN: begin
          // strict less-than keeps the lowest index on a tie
          if (alu_rsp.borrow) begin
            best_r <= scan_val;
            pick_r <= idx_r[IDX_W-1:0];
          end
          idx_r <= idx_r + CNT_W'(1);
          if (idx_r == act_cnt - CNT_W'(1)) begin
            state_r <= S_WCHK;
          end
        end
        S_WCHK: begin
          wait_r  <= alu_rsp.borrow ? '0 : alu_rsp.res[TIME_W-1:0];
          state_r <= S_ICHK;
        end
        S_ICHK: begin
          idle_r  <= alu_rsp.borrow ? '0 : alu_rsp.res[TIME_W-1:0];
          busy_r  <= alu_rsp.borrow;    // server still busy at arrival
          state_r <= S_FREE;
        end
        S_FREE: begin
          new_free_r <= alu_rsp.res[TIME_W-1:0];
          state_r    <= S_WSUM;
        end
        S_WSUM: begin
          wsum_r  <= alu_rsp.res;
          state_r <= S_ISUM;
        end
        S_ISUM: begin
          isum_r  <= alu_rsp.res;
          state_r <= S_JOBS;
        end
        S_JOBS: begin
          jobs_r  <= alu_rsp.res[JOB_W-1:0];
          state_r <= S_TWAIT;
        end
        S_TWAIT: begin
          twait_r <= alu_rsp.res;
          state_r <= S_TIDLE;
        end
        S_TIDLE: begin
          tidle_r <= alu_rsp.res;
          state_r <= S_TJOBS;
        end
        S_TJOBS: begin
          tjobs_r <= alu_rsp.res[JOB_W-1:0];
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            free_at_r[pick_r]  <= new_free_r;
            wait_sum_r[pick_r] <= wsum_r;
            idle_sum_r[pick_r] <= isum_r;
            job_cnt_r[pick_r]  <= jobs_r;
            tot_wait_r <= twait_r;
            tot_idle_r <= tidle_r;
            tot_jobs_r <= tjobs_r;

            out_valid_r <= 1'b1;
            o_server_r  <= SRV_W'(pick_r);
            o_wait_r    <= wait_r;
            o_idle_r    <= idle_r;
            o_sjobs_r   <= jobs_r;
            o_swait_r   <= wsum_r;
            o_sidle_r   <= isum_r;
            o_ajobs_r   <= tjobs_r;
            o_await_r   <= twait_r;
            o_aidle_r   <= tidle_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_server          = o_server_r;
  assign out_wait_time       = o_wait_r;
  assign out_idle_time       = o_idle_r;
  assign out_server_jobs     = o_sjobs_r;
  assign out_server_wait_sum = o_swait_r;
  assign out_server_idle_sum = o_sidle_r;
  assign out_all_jobs        = o_ajobs_r;
  assign out_all_wait_sum    = o_await_r;
  assign out_all_idle_sum    = o_aidle_r;

endmodule

[rtl/core/efsd_checker.sv]
// ----------------------------------------------------------------------------
// efsd_checker: port-level checks for the dispatcher
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module efsd_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [efsd_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [efsd_pkg::TIME_W-1:0]  in_arrival_time,
  input  logic [efsd_pkg::SVC_W-1:0]   in_service_time,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [efsd_pkg::SRV_W-1:0]   out_server,
  input  logic [efsd_pkg::TIME_W-1:0]  out_wait_time,
  input  logic [efsd_pkg::TIME_W-1:0]  out_idle_time,
  input  logic [efsd_pkg::JOB_W-1:0]   out_server_jobs,
  input  logic [efsd_pkg::SUM_W-1:0]   out_server_wait_sum,
  input  logic [efsd_pkg::SUM_W-1:0]   out_server_idle_sum,
  input  logic [efsd_pkg::JOB_W-1:0]   out_all_jobs,
  input  logic [efsd_pkg::SUM_W-1:0]   out_all_wait_sum,
  input  logic [efsd_pkg::SUM_W-1:0]   out_all_idle_sum
);
  import efsd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_server) &&
      $stable(out_wait_time) && $stable(out_all_jobs))
    else $error("result changed while stalled");

  // a request keeps the dispatcher busy: no back-to-back accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted on consecutive cycles");

  // a job either waits or finds its server idle, never both
  a_wait_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_wait_time != '0) |-> (out_idle_time == '0))
    else $error("wait and idle both nonzero");

  // per-server totals never exceed overall totals
  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_all_jobs >= out_server_jobs) &&
      (out_all_wait_sum >= out_server_wait_sum) &&
      (out_all_idle_sum >= out_server_idle_sum))
    else $error("server total above overall total");

  // reset leaves no result pending and the request side open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind earliest_free_server_dispatch efsd_checker u_efsd_checker (.*);
